### rtl/arwf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arwf_pkg
// Shared types and codes of the anti-replay window filter.
// ----------------------------------------------------------------------------
package arwf_pkg;

  localparam int unsigned CTR_W = 64;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned TC_W  = 2;
  localparam int unsigned IDX_W = 32;
  localparam int unsigned PAY_W = 16;

  localparam logic [TC_W-1:0] TC_DATA      = 2'd0;
  localparam logic [TC_W-1:0] TC_KEEPALIVE = 2'd1;

  typedef enum logic [2:0] {
    R_OK       = 3'd0,
    R_SHORT    = 3'd1,
    R_BAD_TYPE = 3'd2,
    R_BAD_RCV  = 3'd3,
    R_AUTH     = 3'd4,
    R_ZERO     = 3'd5,
    R_OLD      = 3'd6,
    R_DUP      = 3'd7
  } reason_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    reason_e          pre;
    logic [CTR_W-1:0] ctr;
    logic [PAY_W-1:0] pay;
  } mid_t;

  // Finished result
  typedef struct packed {
    logic             accept;
    reason_e          reason;
    logic [PAY_W-1:0] pay;
  } res_t;

endpackage
`default_nettype wire

### rtl/anti_replay_window_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anti_replay_window_filter
// Receive-side header check and sliding replay window for transport messages.
// ----------------------------------------------------------------------------
// One item is taken per clock while full is low and one result leaves per
// clock while pop is high and empty is low; every item gives exactly one
// result, in order. A taken item is classified into the classifier queue,
// then the window stage writes its verdict into the output queue. The window
// stage sets the rate: it compares, subtracts and shifts the WINDOW_BITS mask
// for one item each cycle unless the output queue is full. The user must write
// local_index with cfg_we_i only while the block is idle (not enforced here).
module anti_replay_window_filter import arwf_pkg::*; #(
  parameter int unsigned WINDOW_BITS  = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_wdata_i,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [LEN_W-1:0] message_length_i,
  input  wire logic [TC_W-1:0]  type_class_i,
  input  wire logic [IDX_W-1:0] receiver_index_i,
  input  wire logic             auth_ok_i,
  input  wire logic [CTR_W-1:0] msg_counter_i,
  input  wire logic [PAY_W-1:0] payload_bytes_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  accept_o,
  output logic      [2:0]       reason_o,
  output logic      [PAY_W-1:0] payload_len_out_o
);

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  mid_t mid_in, mid_out;
  res_t res_in, res_out;
  logic mid_empty, mid_pop;
  logic res_full, res_push;

  arwf_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .message_length_i(message_length_i),
    .type_class_i    (type_class_i),
    .receiver_index_i(receiver_index_i),
    .auth_ok_i       (auth_ok_i),
    .msg_counter_i   (msg_counter_i),
    .payload_bytes_i (payload_bytes_i),
    .mid_o           (mid_in)
  );

  arwf_fifo #(
    .WIDTH($bits(mid_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(mid_in),
    .full_o (full),
    .pop_i  (mid_pop),
    .rdata_o(mid_out),
    .empty_o(mid_empty)
  );

  arwf_back #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_valid_i(~mid_empty),
    .mid_i      (mid_out),
    .mid_pop_o  (mid_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  arwf_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign accept_o          = res_out.accept;
  assign reason_o          = res_out.reason;
  assign payload_len_out_o = res_out.pay;

`ifndef NO_ASSERTIONS
  a_accept_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (accept_o == (reason_o == R_OK)))
    else $error("accept flag disagrees with reason code");

  a_reject_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !accept_o) |-> (payload_len_out_o == '0))
    else $error("rejected result carries a payload length");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule
`default_nettype wire

### rtl/arwf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arwf_fifo
// Small register queue with show-ahead read data.
// ----------------------------------------------------------------------------
module arwf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### rtl/arwf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arwf_front
// Header classifier: holds the local index and runs the stateless checks.
// ----------------------------------------------------------------------------
module arwf_front import arwf_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_wdata_i,
  input  wire logic [LEN_W-1:0] message_length_i,
  input  wire logic [TC_W-1:0]  type_class_i,
  input  wire logic [IDX_W-1:0] receiver_index_i,
  input  wire logic             auth_ok_i,
  input  wire logic [CTR_W-1:0] msg_counter_i,
  input  wire logic [PAY_W-1:0] payload_bytes_i,
  output mid_t                  mid_o
);

  logic [IDX_W-1:0] local_index_q;
  reason_e          pre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_index_q <= '0;
    end else if (cfg_we_i) begin
      local_index_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (message_length_i < LEN_W'(HEADER_BYTES)) begin
      pre = R_SHORT;
    end else if (type_class_i != TC_DATA && type_class_i != TC_KEEPALIVE) begin
      pre = R_BAD_TYPE;
    end else if (receiver_index_i != local_index_q) begin
      pre = R_BAD_RCV;
    end else if (!auth_ok_i) begin
      pre = R_AUTH;
    end else if (msg_counter_i == '0) begin
      pre = R_ZERO;
    end else begin
      pre = R_OK;
    end
  end

  assign mid_o.pre = pre;
  assign mid_o.ctr = msg_counter_i;
  assign mid_o.pay = payload_bytes_i;

endmodule
`default_nettype wire

### rtl/arwf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arwf_back
// Replay window: checks the counter against the sliding mask and updates it.
// ----------------------------------------------------------------------------
module arwf_back import arwf_pkg::*; #(
  parameter int unsigned WINDOW_BITS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic mid_valid_i,
  input  mid_t      mid_i,
  output logic      mid_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int unsigned SW = $clog2(WINDOW_BITS);

  logic [WINDOW_BITS-1:0] mask_q, mask_d;
  logic [CTR_W-1:0]       hi_q, hi_d;
  logic [CTR_W-1:0]       d_up, d_dn;
  logic [SW-1:0]          sh_up, sh_dn;
  logic                   newer, go;
  reason_e                reason;

  assign go         = mid_valid_i & ~res_full_i;
  assign mid_pop_o  = go;
  assign res_push_o = go;

  assign newer = (mid_i.ctr > hi_q);
  assign d_up  = mid_i.ctr - hi_q;
  assign d_dn  = hi_q - mid_i.ctr;
  assign sh_up = d_up[SW-1:0];
  assign sh_dn = d_dn[SW-1:0];

  always_comb begin
    reason = mid_i.pre;
    mask_d = mask_q;
    hi_d   = hi_q;
    if (mid_i.pre == R_OK) begin
      if (newer) begin
        if (d_up < CTR_W'(WINDOW_BITS)) begin
          mask_d = (mask_q << sh_up) | WINDOW_BITS'(1);
        end else begin
          mask_d = WINDOW_BITS'(1);
        end
        hi_d = mid_i.ctr;
      end else if (d_dn >= CTR_W'(WINDOW_BITS)) begin
        reason = R_OLD;
      end else if (mask_q[sh_dn]) begin
        reason = R_DUP;
      end else begin
        mask_d = mask_q | (WINDOW_BITS'(1) << sh_dn);
      end
    end
  end

  assign res_o.accept = (reason == R_OK);
  assign res_o.reason = reason;
  assign res_o.pay    = (reason == R_OK) ? mid_i.pay : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      hi_q   <= '0;
    end else if (go && reason == R_OK) begin
      mask_q <= mask_d;
      hi_q   <= hi_d;
    end
  end

endmodule
`default_nettype wire
